// ===== hw/rtl/b64d_pkg.sv =====
package b64d_pkg;

  // Character codes used by the classifier
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharEq    = 8'h3D;

  // Sextet values above the alphabet mark padding and bad characters
  localparam logic [6:0] SextetPad = 7'd64;
  localparam logic [6:0] SextetBad = 7'd65;

  // Status codes carried by the closing item of a text
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_DATA = 2'd1,
    STAT_LENGTH  = 2'd2,
    STAT_BAD     = 2'd3
  } status_t;

  // Pending-item mask bits of a queue entry, in emit order
  localparam int unsigned PendByte0  = 0;
  localparam int unsigned PendByte1  = 1;
  localparam int unsigned PendByte2  = 2;
  localparam int unsigned PendStatus = 3;

  // One queue entry: a decoded group and/or the closing status
  typedef struct packed {
    logic [23:0] triple;
    logic [3:0]  pend;
    status_t     code;
  } entry_t;

  // Map one character to its sextet, padding or bad code
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] v;
    v = SextetBad;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = 7'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = 7'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 7'(ch - 8'h30 + 8'd52);
    end else if (ch == CharPlus) begin
      v = 7'd62;
    end else if (ch == CharSlash) begin
      v = 7'd63;
    end else if (ch == CharEq) begin
      v = SextetPad;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
module b64d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        ch,
  input  logic              eot,
  output logic              push,
  output b64d_pkg::entry_t  entry
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] held_r, held_nxt;
  logic        tpad_r, tpad_nxt;
  logic        err_r, err_nxt;
  logic        seen_r, seen_nxt;

  logic        is_space;
  logic [6:0]  v;
  logic        is_pad;
  logic [5:0]  val;
  logic [17:0] held_base;

  // Classify the character
  always_comb begin
    is_space = (ch == b64d_pkg::CharSpace) ||
               (ch >= b64d_pkg::CharTab && ch <= b64d_pkg::CharCr);
    v        = b64d_pkg::sextet_of(ch);
    is_pad   = (v == b64d_pkg::SextetPad);
    val      = v[6] ? 6'd0 : v[5:0];
    held_base = (pos_r == 2'd0) ? 18'd0 : held_r;
  end

  // Group state update and queue entry build
  always_comb begin
    pos_nxt  = pos_r;
    held_nxt = held_r;
    tpad_nxt = tpad_r;
    err_nxt  = err_r;
    seen_nxt = seen_r;
    entry.triple = {held_r, val};
    entry.pend   = '0;
    entry.code   = b64d_pkg::STAT_OK;

    if (!is_space) begin
      seen_nxt = 1'b1;
      if (v == b64d_pkg::SextetBad || (is_pad && pos_r < 2'd2)) begin
        err_nxt = 1'b1;
      end
      if (pos_r != 2'd3) begin
        held_nxt = {held_base[11:0], val};
        if (pos_r == 2'd0) begin
          tpad_nxt = 1'b0;
        end
        if (pos_r == 2'd2) begin
          tpad_nxt = is_pad;
        end
        pos_nxt = pos_r + 2'd1;
      end else begin
        if (!err_nxt) begin
          entry.pend[b64d_pkg::PendByte0] = 1'b1;
          entry.pend[b64d_pkg::PendByte1] = !tpad_r;
          entry.pend[b64d_pkg::PendByte2] = !is_pad;
        end
        pos_nxt  = 2'd0;
        held_nxt = '0;
        tpad_nxt = 1'b0;
      end
    end

    // End of text: close with a status item and start over
    if (eot) begin
      entry.pend[b64d_pkg::PendStatus] = 1'b1;
      if (!seen_nxt) begin
        entry.code = b64d_pkg::STAT_NO_DATA;
      end else if (pos_nxt != 2'd0) begin
        entry.code = b64d_pkg::STAT_LENGTH;
      end else if (err_nxt) begin
        entry.code = b64d_pkg::STAT_BAD;
      end
      pos_nxt  = 2'd0;
      held_nxt = '0;
      tpad_nxt = 1'b0;
      err_nxt  = 1'b0;
      seen_nxt = 1'b0;
    end

    push = acc && (entry.pend != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '0;
      tpad_r <= 1'b0;
      err_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      tpad_r <= tpad_nxt;
      err_r  <= err_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
module b64d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64d_pkg::entry_t  din,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output b64d_pkg::entry_t  dout
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64d_pkg::entry_t slot_r [DEPTH];
  b64d_pkg::entry_t slot_nxt [DEPTH];
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    wr_idx;
  logic             do_pop;
  logic             do_push;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign dout     = slot_r[0];
  assign do_pop   = pop && nonempty;
  assign do_push  = push && !full;

  // Head always sits in slot 0; pop shifts everything down by one
  always_comb begin
    wr_idx = cnt_r - CW'(do_pop);
    for (int i = 0; i < DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (do_pop) begin
      for (int i = 0; i + 1 < DEPTH; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (do_push && wr_idx == CW'(i)) begin
        slot_nxt[i] = din;
      end
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
module b64d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  b64d_pkg::entry_t  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_is_status,
  output logic [1:0]        out_status_code,
  output logic              out_last_item
);

  b64d_pkg::entry_t cur_r, cur_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             stat_r, stat_nxt;
  logic [1:0]       code_r, code_nxt;

  logic             out_load;
  logic             emit;
  logic [3:0]       sel;
  logic [3:0]       pend_left;

  // Pick the first pending item of the current entry
  always_comb begin
    sel = 4'b0000;
    if (cur_r.pend[b64d_pkg::PendByte0]) begin
      sel = 4'b0001;
    end else if (cur_r.pend[b64d_pkg::PendByte1]) begin
      sel = 4'b0010;
    end else if (cur_r.pend[b64d_pkg::PendByte2]) begin
      sel = 4'b0100;
    end else if (cur_r.pend[b64d_pkg::PendStatus]) begin
      sel = 4'b1000;
    end
    pend_left = cur_r.pend & ~sel;
  end

  // Output register loads when empty or drained
  always_comb begin
    out_load = !ov_r || !out_stall;
    emit     = out_load && (cur_r.pend != '0);
    q_pop    = q_nonempty && ((cur_r.pend == '0) || (emit && pend_left == '0));

    cur_nxt = cur_r;
    if (emit) begin
      cur_nxt.pend = pend_left;
    end
    if (q_pop) begin
      cur_nxt = q_data;
    end

    ov_nxt   = emit ? 1'b1 : (out_load ? 1'b0 : ov_r);
    byte_nxt = byte_r;
    stat_nxt = stat_r;
    code_nxt = code_r;
    if (emit) begin
      stat_nxt = sel[b64d_pkg::PendStatus];
      code_nxt = sel[b64d_pkg::PendStatus] ? cur_r.code : b64d_pkg::STAT_OK;
      case (1'b1)
        sel[b64d_pkg::PendByte0]: byte_nxt = cur_r.triple[23:16];
        sel[b64d_pkg::PendByte1]: byte_nxt = cur_r.triple[15:8];
        sel[b64d_pkg::PendByte2]: byte_nxt = cur_r.triple[7:0];
        default:                  byte_nxt = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    stat_r <= stat_nxt;
    code_r <= code_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = byte_r;
  assign out_is_status   = stat_r;
  assign out_status_code = code_r;
  assign out_last_item   = stat_r;

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Channel | Ports                                                | Item
// in      | in_valid, in_stall, in_byte, in_end_of_text          | one text character
// out     | out_valid, out_stall, out_byte, out_is_status,       | data byte or
//         | out_status_code, out_last_item                       | end-of-text status
//
// One character is accepted per clock while the entry queue has room.
// Each character gives up to four output items, sent one per clock from
// the output register while out_stall is low. An accepted character goes
// through a queue slot, the current-entry register and the output register.
// Reset (rst_n low, synchronous) empties the queue and clears group state.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full.
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_status,
  output logic [1:0] out_status_code,
  output logic       out_last_item
);

  logic             acc;
  logic             push;
  b64d_pkg::entry_t entry;
  logic             q_full;
  logic             q_nonempty;
  logic             q_pop;
  b64d_pkg::entry_t q_data;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // Front: classify characters and build group entries
  b64d_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_byte),
    .eot   (in_end_of_text),
    .push  (push),
    .entry (entry)
  );

  // Entry queue between front and back
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (entry),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .dout     (q_data)
  );

  // Back: serialize entries into output items
  b64d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_last_item   (out_last_item)
  );

endmodule

// ===== dv/base64_stream_decoder_tb.sv =====
module base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 100000;
  localparam int          HoldCycles = 80;

  // One decoded item as the consumer sees it
  typedef struct {
    logic [7:0]        data;
    logic              is_status;
    b64d_pkg::status_t code;
    logic              last;
  } dec_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_status;
  logic [1:0] out_status_code;
  logic       out_last_item;

  // Decoder state mirrored by the predictor
  logic [1:0]  grp_pos;
  logic [17:0] held;
  logic        third_pad;
  logic        bad_seen;
  logic        any_seen;

  dec_item_t   pending_q[$];
  dec_item_t   front_item;
  logic [7:0]  text_q[$];

  int          fail_count;
  int          items_sent;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_seq;

  base64_stream_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_last_item   (out_last_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("base64_stream_decoder test failed");
    $finish;
  end

  // Receiver: a long hold-off when asked, random stalls otherwise
  initial begin : receiver
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endfunction

  // Compare each accepted output item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_failure($sformatf("unexpected item byte=%02h status=%0b code=%0d last=%0b",
                               out_byte, out_is_status, out_status_code, out_last_item));
      end else begin
        front_item = pending_q.pop_front();
        if (out_byte !== front_item.data || out_is_status !== front_item.is_status ||
            out_status_code !== front_item.code || out_last_item !== front_item.last) begin
          note_failure($sformatf(
              {"exp byte=%02h status=%0b code=%0d last=%0b ",
               "got byte=%02h status=%0b code=%0d last=%0b"},
              front_item.data, front_item.is_status, front_item.code, front_item.last,
              out_byte, out_is_status, out_status_code, out_last_item));
        end
      end
    end
  end

  // Sextet of a character; padding and bad characters get the package codes
  function automatic logic [6:0] char_value(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return 7'(ch - 8'h41);
    if (ch >= 8'h61 && ch <= 8'h7A) return 7'(ch - 8'h47);  // 'a' is 26
    if (ch >= 8'h30 && ch <= 8'h39) return 7'(ch + 8'd4);   // '0' is 52
    if (ch == b64d_pkg::CharPlus) return 7'd62;
    if (ch == b64d_pkg::CharSlash) return 7'd63;
    if (ch == b64d_pkg::CharEq) return b64d_pkg::SextetPad;
    return b64d_pkg::SextetBad;
  endfunction

  function automatic void push_item(input logic [7:0] data, input logic is_status,
                                    input b64d_pkg::status_t code);
    dec_item_t it;
    it.data      = data;
    it.is_status = is_status;
    it.code      = code;
    it.last      = is_status;
    pending_q    = {pending_q, it};
  endfunction

  function automatic void clear_decoder();
    grp_pos   = 2'd0;
    held      = '0;
    third_pad = 1'b0;
    bad_seen  = 1'b0;
    any_seen  = 1'b0;
  endfunction

  // Work out the items that one accepted character gives
  function automatic void predict_char(input logic [7:0] ch, input logic eot);
    logic [6:0]        v;
    logic [5:0]        val;
    logic [23:0]       triple;
    b64d_pkg::status_t code;
    if (!(ch == b64d_pkg::CharSpace ||
          (ch >= b64d_pkg::CharTab && ch <= b64d_pkg::CharCr))) begin
      v = char_value(ch);
      val = (v < b64d_pkg::SextetPad) ? v[5:0] : 6'd0;
      any_seen = 1'b1;
      if (v == b64d_pkg::SextetBad || (v == b64d_pkg::SextetPad && grp_pos < 2'd2)) begin
        bad_seen = 1'b1;
      end
      if (grp_pos != 2'd3) begin
        if (grp_pos == 2'd0) begin
          held = '0;
          third_pad = 1'b0;
        end
        held = {held[11:0], val};
        if (grp_pos == 2'd2) third_pad = (v == b64d_pkg::SextetPad);
        grp_pos++;
      end else begin
        // group complete: up to three bytes unless an error was seen
        triple = {held, val};
        if (!bad_seen) begin
          push_item(triple[23:16], 1'b0, b64d_pkg::STAT_OK);
          if (!third_pad) push_item(triple[15:8], 1'b0, b64d_pkg::STAT_OK);
          if (v != b64d_pkg::SextetPad) push_item(triple[7:0], 1'b0, b64d_pkg::STAT_OK);
        end
        grp_pos   = 2'd0;
        held      = '0;
        third_pad = 1'b0;
      end
    end
    if (eot) begin
      if (!any_seen) code = b64d_pkg::STAT_NO_DATA;
      else if (grp_pos != 2'd0) code = b64d_pkg::STAT_LENGTH;
      else if (bad_seen) code = b64d_pkg::STAT_BAD;
      else code = b64d_pkg::STAT_OK;
      push_item(8'h00, 1'b1, code);
      clear_decoder();
    end
  endfunction

  // Offer one character, hold it while stalled, return at the next falling edge
  task automatic send_char(input logic [7:0] ch, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= ch;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(ch, eot);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? b64d_pkg::CharSpace : 8'(b64d_pkg::CharTab + r);
  endfunction

  function automatic logic [7:0] rand_b64();
    string alphabet;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alphabet[$urandom_range(63)];
  endfunction

  // Mostly well-formed texts with random content, some broken, some noise
  task automatic send_random_text();
    int          kind;
    int          groups;
    int          r;
    logic [7:0]  grp[4];
    text_q.delete();
    kind = $urandom_range(19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 3)) text_q = {text_q, rand_space()};
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 10)) text_q = {text_q, 8'($urandom_range(255))};
    end else begin
      groups = $urandom_range(1, 3);
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) grp[k] = rand_b64();
        r = $urandom_range(7);
        if (r == 0) begin
          grp[2] = b64d_pkg::CharEq;
          grp[3] = b64d_pkg::CharEq;
        end else if (r == 1) begin
          grp[3] = b64d_pkg::CharEq;
        end else if (r == 2) begin
          grp[2] = b64d_pkg::CharEq;
        end
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(7) == 0) text_q = {text_q, rand_space()};
          text_q = {text_q, grp[k]};
        end
      end
      // broken variants: short, long, misplaced padding, stray byte
      if (kind == 2) begin
        text_q.delete($urandom_range(text_q.size() - 1));
      end else if (kind == 3) begin
        text_q.insert($urandom_range(text_q.size()), rand_b64());
      end else if (kind == 4) begin
        text_q[$urandom_range(text_q.size() - 1)] = b64d_pkg::CharEq;
      end else if (kind == 5) begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
      if ($urandom_range(7) == 0) text_q = {text_q, rand_space()};
    end
    send_text_q();
  endtask

  // Status priority, padding rules, bad characters, byte extremes
  task automatic test_directed();
    send_idle_pct = 15;
    recv_idle_pct = 74;
    send_char(b64d_pkg::CharSpace, 1'b1);  // whitespace only: no data
    send_str("AB=C\n+/==");                // padding in third place, then midstream
    send_str("09=");                       // length not a multiple of four
    send_char(8'hFF, 1'b0);                // bad byte, later bytes suppressed
    send_str("AAA=AAA");                   // padding first in a group
    send_str("A=AA");                      // padding second in a group
    send_char(8'h00, 1'b1);                // single bad byte: length wins
    wait_drained();
  endtask

  // Long receiver hold-off fills the queue; then the sender waits for all items
  task automatic test_fill_and_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq++;
    send_str("TWFu TWFuYQ== QUJD TWFu TWFuYQ== QUJD");
    wait_drained();
    send_str("+/+/////AAAA");
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_random_text();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    clear_decoder();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_stall();
    test_random_traffic(15, 74, 45);
    test_random_traffic(74, 15, 45);
    test_random_traffic(0, 0, 45);

    recv_idle_pct = 0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("base64_stream_decoder test passed");
    end else begin
      $display("base64_stream_decoder test failed");
    end
    $finish;
  end

endmodule
